FILE: sv/hrm_pkg.sv
package hrm_pkg;

  localparam int MAP_SIDE_DEF = 256;
  // 255 * 3: full-white channel sum
  localparam int HEIGHT_DIV = 765;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH   = 3'd0,
    REG_MAP_HEIGHT  = 3'd1,
    REG_PEAK_HEIGHT = 3'd2,
    REG_SCALE       = 3'd3,
    REG_ORIGIN_X    = 3'd4,
    REG_ORIGIN_Y    = 3'd5,
    REG_ORIGIN_Z    = 3'd6,
    REG_MARCH_STEP  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic               kind;
    logic [15:0]        texel_addr;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [31:0] ray_x;
    logic signed [31:0] ray_y;
    logic signed [31:0] ray_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } out_t;

  typedef struct packed {
    logic [8:0]         map_width;
    logic [8:0]         map_height;
    logic [15:0]        peak_height;
    logic [23:0]        world_to_map_scale;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [22:0]        march_step;
  } cfg_t;

endpackage

FILE: sv/heightmap_ray_march.sv
// Heightmap ray marcher.
// Input: an item is taken at a clock edge where start is high and busy is
// low. kind selects a texel load (writes red+green+blue into the height
// store) or a ray query (origin plus direction of any length).
// Items enter a two-word queue; busy rises only when the queue is full.
// Output: each query gives exactly one word on out_o, marked by done_o for
// one cycle; loads give none. The receiver cannot stall, so results are
// never held back. Hit coordinates are zero on a miss.
// Config: cfg_valid_i/cfg_index_i/cfg_data_i write register cfg_index_i;
// cfg_ready_o is always high. Write only while the block is idle.
// Sequence: a load is written to the height store as it leaves the queue.
// A query runs setup (3 squaring, 32 root and 3 x 48 divide steps), then
// up to 2*map_width/march_step march steps through S_PT, S_MAP, S_IDX,
// plus S_MUL, S_CMP on the map. The sequential step loop sets the rate.
// Reset: clears control and restores register defaults; the height store
// is not cleared and holds garbage until loaded.
module heightmap_ray_march import hrm_pkg::*; #(
  parameter int MAP_SIDE = MAP_SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         in_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output out_t        out_o
);

  logic full, avail, pop;
  in_t  head;
  cfg_t cfg;

  assign busy        = full;
  assign cfg_ready_o = 1'b1;

  hrm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start && !full),
    .item_i      (in_i),
    .full_o      (full),
    .pop_i       (pop),
    .avail_o     (avail),
    .head_o      (head),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hrm_back #(.MAP_SIDE(MAP_SIDE)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .avail_i (avail),
    .head_i  (head),
    .pop_o   (pop),
    .done_o  (done_o),
    .out_o   (out_o)
  );

endmodule

FILE: sv/hrm_front.sv
module hrm_front import hrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  in_t         item_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        avail_o,
  output in_t         head_o,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  // two-word queue between intake and marcher
  in_t        buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cfg_t       cfg_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign head_o  = buf_q[rp_q];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
      cfg_q.map_width          <= 9'd256;
      cfg_q.map_height         <= 9'd256;
      cfg_q.peak_height        <= 16'd200;
      cfg_q.world_to_map_scale <= 24'd32768;
      cfg_q.origin_x           <= 32'shFE70_0000;
      cfg_q.origin_y           <= 32'sd0;
      cfg_q.origin_z           <= 32'shFE70_0000;
      cfg_q.march_step         <= 23'd6554;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MAP_WIDTH:   cfg_q.map_width          <= cfg_data_i[8:0];
          REG_MAP_HEIGHT:  cfg_q.map_height         <= cfg_data_i[8:0];
          REG_PEAK_HEIGHT: cfg_q.peak_height        <= cfg_data_i[15:0];
          REG_SCALE:       cfg_q.world_to_map_scale <= cfg_data_i[23:0];
          REG_ORIGIN_X:    cfg_q.origin_x           <= cfg_data_i;
          REG_ORIGIN_Y:    cfg_q.origin_y           <= cfg_data_i;
          REG_ORIGIN_Z:    cfg_q.origin_z           <= cfg_data_i;
          REG_MARCH_STEP:  cfg_q.march_step         <= cfg_data_i[22:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: sv/hrm_back.sv
module hrm_back import hrm_pkg::*; #(
  parameter int MAP_SIDE = MAP_SIDE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic avail_i,
  input  in_t  head_i,
  output logic pop_o,
  output logic done_o,
  output out_t out_o
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ROOT, S_DIV, S_PT, S_MAP, S_IDX, S_MUL, S_CMP
  } state_e;

  state_e             state_q;
  in_t                item_q;
  logic [1:0]         sel_q;
  logic [5:0]         cnt_q;
  logic [63:0]        acc_q;
  logic [31:0]        root_q;
  logic [31:0]        rem_q;
  logic [47:0]        num_q;
  logic [16:0]        quo_q;
  logic [16:0]        umag_q [3];
  logic               uneg_q [3];
  logic [25:0]        d_q;
  logic signed [33:0] px_q, py_q, pz_q;
  logic signed [59:0] tx_q, tz_q;
  logic signed [34:0] dy_q;
  logic [25:0]        prod_q;
  logic signed [45:0] dyk_q;
  logic               done_q;
  out_t               res_q;

  logic [9:0] mem [DEPTH];
  logic [9:0] rd_q;

  // effective map size and step
  logic [8:0]  w, h;
  logic [22:0] step;
  logic [25:0] maxd;
  assign w    = ({23'd0, cfg_i.map_width}  > MAP_SIDE) ? 9'(MAP_SIDE) : cfg_i.map_width;
  assign h    = ({23'd0, cfg_i.map_height} > MAP_SIDE) ? 9'(MAP_SIDE) : cfg_i.map_height;
  assign step = (cfg_i.march_step == 23'd0) ? 23'd1 : cfg_i.march_step;
  assign maxd = {w, 17'd0};

  // load path
  logic        wr_en;
  logic [31:0] waddr32;
  assign pop_o   = (state_q == S_IDLE) && avail_i;
  assign waddr32 = {16'd0, head_i.texel_addr};
  assign wr_en   = pop_o && (head_i.kind == KIND_LOAD) && (waddr32 < DEPTH);

  // squared length
  logic signed [31:0] dsel;
  logic [31:0]        dmag;
  logic [63:0]        sq;
  always_comb begin
    case (sel_q)
      2'd0:    dsel = item_q.dir_x;
      2'd1:    dsel = item_q.dir_y;
      default: dsel = item_q.dir_z;
    endcase
  end
  assign dmag = dsel[31] ? (32'd0 - dsel) : dsel;
  assign sq   = dmag * dmag;

  // square root trial
  logic [31:0] trial;
  logic [63:0] tsq;
  assign trial = root_q | (32'd1 << cnt_q[4:0]);
  assign tsq   = trial * trial;

  // restoring divide step
  logic [32:0] r2;
  logic        qbit;
  logic [16:0] quo_n;
  assign r2    = {rem_q, num_q[47]};
  assign qbit  = (r2 >= {1'b0, root_q});
  assign quo_n = {quo_q[15:0], qbit};

  // point on the ray
  logic [42:0]        mx, my, mz;
  logic signed [33:0] px_d, py_d, pz_d;
  assign mx = umag_q[0] * d_q;
  assign my = umag_q[1] * d_q;
  assign mz = umag_q[2] * d_q;
  assign px_d = 34'(item_q.ray_x) + (uneg_q[0] ? -$signed({7'd0, mx[42:16]})
                                               :  $signed({7'd0, mx[42:16]}));
  assign py_d = 34'(item_q.ray_y) + (uneg_q[1] ? -$signed({7'd0, my[42:16]})
                                               :  $signed({7'd0, my[42:16]}));
  assign pz_d = 34'(item_q.ray_z) + (uneg_q[2] ? -$signed({7'd0, mz[42:16]})
                                               :  $signed({7'd0, mz[42:16]}));

  // map coordinates, signed Q28.32
  logic signed [34:0] rx, rz;
  logic signed [24:0] scs;
  logic signed [59:0] tx_d, tz_d;
  assign rx   = 35'(px_q) - 35'(cfg_i.origin_x);
  assign rz   = 35'(pz_q) - 35'(cfg_i.origin_z);
  assign scs  = $signed({1'b0, cfg_i.world_to_map_scale});
  assign tx_d = rx * scs;
  assign tz_d = rz * scs;

  logic        onmap;
  logic [17:0] izw;
  logic [31:0] idx32;
  assign onmap = !tx_q[59] && !tz_q[59]
              && (tx_q < $signed({19'd0, w, 32'd0}))
              && (tz_q < $signed({19'd0, h, 32'd0}));
  assign izw   = tz_q[40:32] * w;
  assign idx32 = {14'd0, izw} + {23'd0, tx_q[40:32]};

  logic rd_en;
  assign rd_en = (state_q == S_IDX) && onmap;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr32[AW-1:0]] <= 10'(head_i.red) + 10'(head_i.green) + 10'(head_i.blue);
    if (rd_en) rd_q <= mem[idx32[AW-1:0]];
  end

  // terrain test: py - oy <= floor(sum*peak*65536/765) without a divide
  logic        strike;
  logic [25:0] dn;
  assign strike = dyk_q <= $signed({4'd0, prod_q, 16'd0});
  assign dn     = d_q + 26'(step);

  assign done_o = done_q;
  assign out_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (avail_i && head_i.kind == KIND_QUERY) begin
            item_q  <= head_i;
            acc_q   <= 64'd0;
            sel_q   <= 2'd0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          done_q <= 1'b0;
          acc_q  <= acc_q + sq;
          if (sel_q == 2'd2) begin
            root_q  <= 32'd0;
            cnt_q   <= 6'd31;
            state_q <= S_ROOT;
          end else begin
            sel_q <= sel_q + 2'd1;
          end
        end
        S_ROOT: begin
          if (tsq <= acc_q) root_q <= trial;
          if (cnt_q == 6'd0) begin
            if ((root_q | ((tsq <= acc_q) ? trial : 32'd0)) == 32'd0) begin
              for (int i = 0; i < 3; i++) begin
                umag_q[i] <= 17'd0;
                uneg_q[i] <= 1'b0;
              end
              d_q <= 26'd0;
              if (w == 9'd0) begin
                res_q   <= '0;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                done_q  <= 1'b0;
                state_q <= S_PT;
              end
            end else begin
              done_q  <= 1'b0;
              sel_q   <= 2'd0;
              num_q   <= {(item_q.dir_x[31] ? 32'd0 - item_q.dir_x : item_q.dir_x), 16'd0};
              rem_q   <= 32'd0;
              quo_q   <= 17'd0;
              cnt_q   <= 6'd47;
              state_q <= S_DIV;
            end
          end else begin
            done_q <= 1'b0;
            cnt_q  <= cnt_q - 6'd1;
          end
        end
        S_DIV: begin
          if (cnt_q == 6'd0) begin
            umag_q[sel_q] <= quo_n;
            uneg_q[sel_q] <= dsel[31];
            if (sel_q == 2'd2) begin
              d_q <= 26'd0;
              if (w == 9'd0) begin
                res_q   <= '0;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                done_q  <= 1'b0;
                state_q <= S_PT;
              end
            end else begin
              done_q <= 1'b0;
              sel_q  <= sel_q + 2'd1;
              num_q  <= {(sel_q == 2'd0)
                         ? (item_q.dir_y[31] ? 32'd0 - item_q.dir_y : item_q.dir_y)
                         : (item_q.dir_z[31] ? 32'd0 - item_q.dir_z : item_q.dir_z), 16'd0};
              rem_q  <= 32'd0;
              quo_q  <= 17'd0;
              cnt_q  <= 6'd47;
            end
          end else begin
            done_q <= 1'b0;
            rem_q  <= qbit ? 32'(r2 - {1'b0, root_q}) : r2[31:0];
            quo_q  <= quo_n;
            num_q  <= {num_q[46:0], 1'b0};
            cnt_q  <= cnt_q - 6'd1;
          end
        end
        S_PT: begin
          done_q  <= 1'b0;
          px_q    <= px_d;
          py_q    <= py_d;
          pz_q    <= pz_d;
          state_q <= S_MAP;
        end
        S_MAP: begin
          done_q  <= 1'b0;
          tx_q    <= tx_d;
          tz_q    <= tz_d;
          dy_q    <= 35'(py_q) - 35'(cfg_i.origin_y);
          state_q <= S_IDX;
        end
        S_IDX: begin
          if (onmap) begin
            done_q  <= 1'b0;
            state_q <= S_MUL;
          end else if (dn >= maxd) begin
            res_q   <= '0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            done_q  <= 1'b0;
            d_q     <= dn;
            state_q <= S_PT;
          end
        end
        S_MUL: begin
          done_q  <= 1'b0;
          prod_q  <= rd_q * cfg_i.peak_height;
          dyk_q   <= dy_q * $signed(11'(HEIGHT_DIV));
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (strike) begin
            res_q.hit   <= 1'b1;
            res_q.hit_x <= px_q[31:0];
            res_q.hit_y <= py_q[31:0];
            res_q.hit_z <= pz_q[31:0];
            done_q      <= 1'b1;
            state_q     <= S_IDLE;
          end else if (dn >= maxd) begin
            res_q   <= '0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            done_q  <= 1'b0;
            d_q     <= dn;
            state_q <= S_PT;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/heightmap_ray_march_test.sv
module heightmap_ray_march_test;
  import hrm_pkg::*;

  localparam int SIDE = MAP_SIDE_DEF;
  // clearing pass is absent
  localparam int DRAIN_CYCLES = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_t         in_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        done_o;
  out_t        out_o;

  heightmap_ray_march dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .done_o(done_o), .out_o(out_o)
  );

  always #6 clk_i = ~clk_i;

  // register shadow, updated when a config word is taken
  cfg_t regs;
  // heights as seen at acceptance, and as planned while building stimulus
  logic [9:0] height_live [SIDE*SIDE];
  logic [9:0] height_plan [SIDE*SIDE];
  bit         plan_loaded [SIDE*SIDE];

  in_t  pend_q[$];   // items waiting to be driven
  out_t hit_q[$];    // expected march results, oldest first
  int   idle_pct;
  int   errors, n_loads, n_queries, n_hits, n_miss;
  int   n_pushed;
  bit   took;

  task automatic report(input string what, input out_t got, input out_t want);
    errors++;
    $display("MISMATCH %s: got hit=%0b (%0d,%0d,%0d) want hit=%0b (%0d,%0d,%0d)", what,
             got.hit, got.hit_x, got.hit_y, got.hit_z,
             want.hit, want.hit_x, want.hit_y, want.hit_z);
  endtask

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // a*b >> 16, toward zero
  function automatic longint qmul(longint a, longint b);
    longint unsigned m;
    m = (mag64(a) * mag64(b)) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unit_of(longint d, longint unsigned len);
    longint unsigned m;
    m = (mag64(d) << 16) / len;
    return (d < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Walk the ray against the planned or live heights. missing returns the
  // first cell read that was never loaded (planned side only), else -1.
  function automatic out_t march_ray(input in_t it, input cfg_t c, input bit plan,
                                     output int missing);
    longint rx, ry, rz, dx, dy, dz, ux, uy, uz, ox, oy, oz, sc, px, py, pz, tx, tz, th;
    longint unsigned len, w, h, stp, maxd, d, idx, sum;
    out_t r;
    r = '0;
    missing = -1;
    rx = it.ray_x; ry = it.ray_y; rz = it.ray_z;
    dx = it.dir_x; dy = it.dir_y; dz = it.dir_z;
    len = root64(mag64(dx) * mag64(dx) + mag64(dy) * mag64(dy) + mag64(dz) * mag64(dz));
    ux = 0; uy = 0; uz = 0;
    if (len != 0) begin
      ux = unit_of(dx, len); uy = unit_of(dy, len); uz = unit_of(dz, len);
    end
    w = (c.map_width > SIDE) ? SIDE : c.map_width;
    h = (c.map_height > SIDE) ? SIDE : c.map_height;
    stp = (c.march_step == 0) ? 1 : c.march_step;
    maxd = w << 17;
    ox = c.origin_x; oy = c.origin_y; oz = c.origin_z;
    sc = longint'(c.world_to_map_scale);
    for (d = 0; d < maxd; d += stp) begin
      px = rx + qmul(ux, longint'(d));
      py = ry + qmul(uy, longint'(d));
      pz = rz + qmul(uz, longint'(d));
      tx = (px - ox) * sc;
      tz = (pz - oz) * sc;
      if (tx < 0 || tx >= longint'(w << 32) || tz < 0 || tz >= longint'(h << 32)) continue;
      idx = (longint'(tz) >>> 32) * w + (longint'(tx) >>> 32);
      if (plan && !plan_loaded[idx]) begin
        missing = int'(idx);
        return r;
      end
      sum = plan ? height_plan[idx] : height_live[idx];
      th = oy + longint'((sum * c.peak_height * 64'd65536) / HEIGHT_DIV);
      if (py <= th) begin
        r.hit = 1'b1;
        r.hit_x = px[31:0];
        r.hit_y = py[31:0];
        r.hit_z = pz[31:0];
        return r;
      end
    end
    return r;
  endfunction

  function automatic in_t junk_item();
    logic [255:0] raw;
    in_t it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_t)-1:0];
    return it;
  endfunction

  task automatic push_load(input int addr, input int rr, input int gg, input int bb);
    in_t it;
    it = junk_item();
    it.kind = KIND_LOAD;
    it.texel_addr = addr[15:0];
    it.red = rr[7:0]; it.green = gg[7:0]; it.blue = bb[7:0];
    height_plan[addr[15:0]] = rr[7:0] + gg[7:0] + bb[7:0];
    plan_loaded[addr[15:0]] = 1'b1;
    n_pushed++;
    pend_q.push_back(it);
  endtask

  // loads any never-written cell the ray would read, then queues the query
  task automatic push_query(input in_t it);
    int miss, guard;
    out_t dummy;
    it.kind = KIND_QUERY;
    guard = 0;
    dummy = march_ray(it, regs, 1'b1, miss);
    while (miss >= 0 && guard < 400) begin
      push_load(miss, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      dummy = march_ray(it, regs, 1'b1, miss);
      guard++;
    end
    n_pushed++;
    pend_q.push_back(it);
  endtask

  // acceptance, prediction and checking
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      int unused;
      took = 1'b1;
      if (in_i.kind == KIND_LOAD) begin
        height_live[in_i.texel_addr] = in_i.red + in_i.green + in_i.blue;
        n_loads++;
      end else begin
        hit_q.push_back(march_ray(in_i, regs, 1'b0, unused));
        n_queries++;
      end
      void'(pend_q.pop_front());
    end
    if (rst_ni && done_o) begin
      if (hit_q.size() == 0) begin
        report("unexpected word", out_o, '0);
      end else begin
        out_t want;
        want = hit_q.pop_front();
        if (want.hit) n_hits++; else n_miss++;
        if (out_o.hit !== want.hit) report("hit", out_o, want);
        else if (out_o.hit_x !== want.hit_x) report("hit_x", out_o, want);
        else if (out_o.hit_y !== want.hit_y) report("hit_y", out_o, want);
        else if (out_o.hit_z !== want.hit_z) report("hit_z", out_o, want);
      end
    end
  end

  // driver: holds a word until taken, idles at random between words
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !took) begin
        // hold
      end else if (pend_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_i  <= pend_q[0];
      end else begin
        start <= 1'b0;
      end
      took = 1'b0;
    end
  end

  task automatic cfg_write(input cfg_reg_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MAP_WIDTH:   regs.map_width = data[8:0];
      REG_MAP_HEIGHT:  regs.map_height = data[8:0];
      REG_PEAK_HEIGHT: regs.peak_height = data[15:0];
      REG_SCALE:       regs.world_to_map_scale = data[23:0];
      REG_ORIGIN_X:    regs.origin_x = data;
      REG_ORIGIN_Y:    regs.origin_y = data;
      REG_ORIGIN_Z:    regs.origin_z = data;
      REG_MARCH_STEP:  regs.march_step = data[22:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || hit_q.size() != 0 || start) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ray origin Q16.16 world coordinate over texel t (Q16.16) along one axis
  function automatic logic [31:0] world_at(input longint o, input longint t);
    longint sc;
    sc = (regs.world_to_map_scale == 0) ? 1 : regs.world_to_map_scale;
    return 32'(o + (t * 65536) / sc);
  endfunction

  // queues about n words, counting the loads added ahead of queries
  task automatic random_phase(input int n);
    in_t it;
    int w, h, k, first;
    w = $urandom_range(1, 16);
    h = $urandom_range(1, 16);
    cfg_write(REG_MAP_WIDTH, w);
    cfg_write(REG_MAP_HEIGHT, h);
    k = $urandom_range(0, 3);
    cfg_write(REG_PEAK_HEIGHT, (k == 0) ? 0 : (k == 1) ? 65535 : $urandom_range(1, 300));
    k = $urandom_range(0, 2);
    cfg_write(REG_SCALE, (k == 0) ? 65536 : $urandom_range(16384, 262144));
    cfg_write(REG_ORIGIN_X, $urandom);
    cfg_write(REG_ORIGIN_Y, $urandom_range(0, 1) ? $urandom : 0);
    cfg_write(REG_ORIGIN_Z, $urandom);
    // at most about 64 steps per query
    cfg_write(REG_MARCH_STEP, $urandom_range((w << 17) / 64 + 1, w << 17));
    first = n_pushed;
    while (n_pushed - first < n) begin
      if ($urandom_range(0, 4) == 0) begin
        push_load($urandom_range(0, 65535), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        it = junk_item();
        if ($urandom_range(0, 7) != 0) begin
          // aimed at or near the map, below to above the tallest terrain
          it.ray_x = world_at(regs.origin_x, $urandom_range(0, (w + 4) << 16) - (2 << 16));
          it.ray_z = world_at(regs.origin_z, $urandom_range(0, (h + 4) << 16) - (2 << 16));
          it.ray_y = 32'(longint'(regs.origin_y)
                         + longint'($urandom_range(0, regs.peak_height + 4)) * 65536
                         - 2 * 65536);
          if ($urandom_range(0, 3) != 0) begin
            it.dir_x = $urandom_range(0, 8 << 16) - (4 << 16);
            it.dir_y = -$urandom_range(0, 4 << 16);
            it.dir_z = $urandom_range(0, 8 << 16) - (4 << 16);
          end
        end
        push_query(it);
      end
    end
    drain();
  endtask

  initial begin
    in_t it;
    int pcts [5] = '{0, 60, 15, 60, 0};
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_MAP_WIDTH;
    cfg_data_i = '0;
    took = 1'b0;
    idle_pct = 0;
    n_pushed = 0;
    regs.map_width = 256;
    regs.map_height = 256;
    regs.peak_height = 200;
    regs.world_to_map_scale = 32768;
    regs.origin_x = -26214400;
    regs.origin_y = 0;
    regs.origin_z = -26214400;
    regs.march_step = 6554;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, at reset defaults: channel and address extremes
    push_load(0, 255, 255, 255);
    push_load(65535, 0, 0, 0);
    push_load(1, 0, 255, 0);
    // below the terrain at cell 0: hit at the ray origin
    it = junk_item();
    it.ray_x = -26148864; it.ray_y = 32'h8000_0000; it.ray_z = -26148864;
    push_query(it);
    // zero direction
    it.dir_x = 0; it.dir_y = 0; it.dir_z = 0;
    push_query(it);
    // extreme direction components
    it.dir_x = 32'h7fff_ffff; it.dir_y = 32'h8000_0000; it.dir_z = 32'h7fff_ffff;
    push_query(it);
    it.dir_x = 32'h8000_0000; it.dir_y = 32'h7fff_ffff; it.dir_z = 32'h8000_0000;
    it.ray_y = 32'h7fff_ffff;
    push_query(it);
    // far off the map: full march, miss
    it = junk_item();
    it.ray_x = 32'h7fff_0000; it.ray_z = 32'h7fff_0000;
    it.dir_x = 65536; it.dir_y = 0; it.dir_z = 0;
    push_query(it);
    drain();

    // oversize width saturates, zero height gives no on-map point
    cfg_write(REG_MAP_WIDTH, 32'hffff_ffff);
    cfg_write(REG_MAP_HEIGHT, 0);
    cfg_write(REG_MARCH_STEP, 32'h0040_0000);
    cfg_write(REG_SCALE, 32'hffff_ffff);
    cfg_write(REG_PEAK_HEIGHT, 32'hffff_ffff);
    it = junk_item();
    push_query(it);
    drain();
    // zero width: no steps at all
    cfg_write(REG_MAP_WIDTH, 0);
    cfg_write(REG_MAP_HEIGHT, 256);
    push_query(it);
    drain();
    // zero step acts as one; zero scale pins every point to cell 0
    cfg_write(REG_MAP_WIDTH, 1);
    cfg_write(REG_MAP_HEIGHT, 1);
    cfg_write(REG_MARCH_STEP, 0);
    cfg_write(REG_SCALE, 0);
    cfg_write(REG_ORIGIN_X, 32'h8000_0000);
    cfg_write(REG_ORIGIN_Y, 32'h7fff_ffff);
    cfg_write(REG_ORIGIN_Z, 32'h7fff_ffff);
    it = junk_item();
    it.ray_y = 32'h8000_0000;
    push_query(it);
    drain();
    cfg_write(REG_PEAK_HEIGHT, 0);

    // random phases under several idling patterns
    foreach (pcts[p]) begin
      idle_pct = pcts[p];
      random_phase(20);
    end
    drain();

    $display("covered %0d loads and %0d ray queries (%0d hits, %0d misses)",
             n_loads, n_queries, n_hits, n_miss);
    $display("map sizes from zero to oversize, zero/max step, scale and height extremes");
    if (errors == 0 && hit_q.size() == 0) begin
      $display("heightmap_ray_march test passed");
    end else begin
      $display("heightmap_ray_march test failed");
    end
    $finish;
  end

  initial begin
    #(12 * 3_000_000);
    $display("heightmap_ray_march test failed");
    $finish;
  end

endmodule
